[rtl/core/hufd_pkg.sv]
// ----------------------------------------------------------------------------
// hufd_pkg: shared types and constants of the Huffman tree loader and decoder
// Holds the request and response structures, operation and result codes,
// the tree status encoding and the storage geometry of the node store and
// the build stack.
// ----------------------------------------------------------------------------
package hufd_pkg;

   // Storage geometry.
   localparam int MAX_INTERNAL_NODES = 256;
   localparam int SYMBOL_BITS        = 8;
   localparam int NODE_W             = $clog2(MAX_INTERNAL_NODES);
   localparam int COUNT_W            = $clog2(MAX_INTERNAL_NODES + 1);
   localparam int STACK_DEPTH        = MAX_INTERNAL_NODES + 1;
   localparam int STACK_AW           = $clog2(STACK_DEPTH);
   localparam int DEPTH_W            = $clog2(STACK_DEPTH + 1);
   localparam int PAYLOAD_W          = (NODE_W > SYMBOL_BITS) ? NODE_W : SYMBOL_BITS;
   localparam int NODE_ENTRIES       = 2 * MAX_INTERNAL_NODES;

   // Operation codes of a request.
   localparam logic [1:0] OP_BEGIN = 2'd0;
   localparam logic [1:0] OP_NODE  = 2'd1;
   localparam logic [1:0] OP_BIT   = 2'd2;
   localparam logic [1:0] OP_END   = 2'd3;

   // Result kinds of a response.
   localparam logic [1:0] KIND_SYMBOL     = 2'd0;
   localparam logic [1:0] KIND_END        = 2'd1;
   localparam logic [1:0] KIND_TREE_ERR   = 2'd2;
   localparam logic [1:0] KIND_DECODE_ERR = 2'd3;

   // Tree status.
   typedef enum logic [3:0] {
      ST_EMPTY    = 4'b0001,
      ST_BUILDING = 4'b0010,
      ST_COMPLETE = 4'b0100,
      ST_FAILED   = 4'b1000
   } status_type;

   typedef struct packed {
      logic [1:0] operation;
      logic       shape_bit;
      logic [7:0] leaf_symbol;
      logic       message_bit;
   } req_type;

   typedef struct packed {
      logic [1:0] kind;
      logic [7:0] symbol;
      logic       partial_dropped;
   } rsp_type;

   // One child entry of the node store: leaf flag plus symbol or node index.
   typedef struct packed {
      logic                 leaf;
      logic [PAYLOAD_W-1:0] payload;
   } child_type;

   // One open child slot on the build stack.
   typedef struct packed {
      logic [NODE_W-1:0] node;
      logic              side;
   } slot_type;

   // Write into the node store from the tree builder.
   typedef struct packed {
      logic            we;
      logic [NODE_W:0] addr;
      child_type       data;
   } node_wr_type;

   // Status from the tree builder.
   typedef struct packed {
      logic tree_error;
      logic completed;
      logic tree_ready;
   } build_stat_type;

endpackage

[rtl/core/huffman_tree_load_and_decode.sv]
// ----------------------------------------------------------------------------
// huffman_tree_load_and_decode: Huffman tree loader and bit-serial decoder
// A taken request's result passes the pending stage register and then the output register to rsp_valid.
// Throughput: one request per cycle; the node store read data feeds the next
// bit's address directly, and req_stall rises only while a result waits on a stalled output.
// Reset clears the tree status to empty, the cursor to the root and all
// valid flags; the node store and build stack hold data until written.
// ----------------------------------------------------------------------------
module huffman_tree_load_and_decode (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  hufd_pkg::req_type req_data,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output hufd_pkg::rsp_type rsp_data
);

   hufd_pkg::node_wr_type             node_wr;
   hufd_pkg::build_stat_type          stat;
   hufd_pkg::child_type               node_mem [hufd_pkg::NODE_ENTRIES];
   hufd_pkg::child_type               node_rd_ff;
   logic                              node_re;
   logic [hufd_pkg::NODE_W:0]         node_raddr;

   logic                              s1_valid_ff, s1_valid_in;
   logic                              s1_decode_ff, s1_decode_in;
   logic                              s1_has_ff, s1_has_in;
   hufd_pkg::rsp_type                 s1_rsp_ff, s1_rsp_in;
   logic                              out_valid_ff, out_valid_in;
   hufd_pkg::rsp_type                 out_rsp_ff, out_rsp_in;
   logic [hufd_pkg::NODE_W-1:0]       cursor_ff, cursor_in;
   logic                              inside_ff, inside_in;

   logic                              accept;
   logic                              out_free;
   logic                              s1_result;
   logic                              s1_done;
   hufd_pkg::rsp_type                 s1_rsp_cur;
   logic [hufd_pkg::NODE_W-1:0]       cursor_eff;
   logic                              inside_eff;

   // Tree builder owns the build stack and the tree status.
   hufd_tree_builder u_builder (
      .clock   (clock),
      .reset   (reset),
      .accept  (accept),
      .req     (req_data),
      .node_wr (node_wr),
      .stat    (stat)
   );

   // Pending stage: a decode step finishes on the registered node read.
   assign s1_result = s1_decode_ff ? node_rd_ff.leaf : s1_has_ff;

   always_comb begin
      s1_rsp_cur = s1_rsp_ff;
      if (s1_decode_ff) begin
         s1_rsp_cur.kind            = hufd_pkg::KIND_SYMBOL;
         s1_rsp_cur.symbol          = 8'(node_rd_ff.payload[hufd_pkg::SYMBOL_BITS-1:0]);
         s1_rsp_cur.partial_dropped = 1'b0;
      end
   end

   // Handshake between the pending stage and the output register.
   assign out_free  = !out_valid_ff || !rsp_stall;
   assign s1_done   = s1_valid_ff && (!s1_result || out_free);
   assign req_stall = s1_valid_ff && !s1_done;
   assign accept    = req_valid && !req_stall;

   // Cursor as seen after the pending decode step, forwarded for the next request.
   always_comb begin
      cursor_eff = cursor_ff;
      inside_eff = inside_ff;
      if (s1_valid_ff && s1_decode_ff) begin
         if (node_rd_ff.leaf) begin
            cursor_eff = '0;
            inside_eff = 1'b0;
         end else begin
            cursor_eff = node_rd_ff.payload[hufd_pkg::NODE_W-1:0];
            inside_eff = 1'b1;
         end
      end
   end

   // Request decode and pending stage update.
   always_comb begin
      cursor_in    = cursor_eff;
      inside_in    = inside_eff;
      node_re      = 1'b0;
      node_raddr   = {cursor_eff, req_data.message_bit};
      s1_valid_in  = s1_valid_ff;
      s1_decode_in = s1_decode_ff;
      s1_has_in    = s1_has_ff;
      s1_rsp_in    = s1_rsp_ff;
      if (s1_done) begin
         s1_valid_in = 1'b0;
      end
      if (accept) begin
         s1_valid_in  = 1'b1;
         s1_decode_in = 1'b0;
         s1_has_in    = 1'b0;
         s1_rsp_in    = '0;
         unique case (req_data.operation)
            hufd_pkg::OP_BEGIN: begin
               cursor_in = '0;
               inside_in = 1'b0;
            end
            hufd_pkg::OP_NODE: begin
               if (stat.tree_error) begin
                  s1_has_in      = 1'b1;
                  s1_rsp_in.kind = hufd_pkg::KIND_TREE_ERR;
               end
               if (stat.completed) begin
                  cursor_in = '0;
                  inside_in = 1'b0;
               end
            end
            hufd_pkg::OP_BIT: begin
               if (stat.tree_ready) begin
                  node_re      = 1'b1;
                  s1_decode_in = 1'b1;
               end else begin
                  s1_has_in      = 1'b1;
                  s1_rsp_in.kind = hufd_pkg::KIND_DECODE_ERR;
               end
            end
            hufd_pkg::OP_END: begin
               s1_has_in = 1'b1;
               if (stat.tree_ready) begin
                  s1_rsp_in.kind            = hufd_pkg::KIND_END;
                  s1_rsp_in.partial_dropped = inside_eff;
                  cursor_in                 = '0;
                  inside_in                 = 1'b0;
               end else begin
                  s1_rsp_in.kind = hufd_pkg::KIND_DECODE_ERR;
               end
            end
            default: begin
               s1_valid_in = 1'b0;
            end
         endcase
      end
   end

   // Output register.
   always_comb begin
      out_valid_in = out_valid_ff;
      out_rsp_in   = out_rsp_ff;
      if (out_free) begin
         out_valid_in = 1'b0;
      end
      if (s1_done && s1_result) begin
         out_valid_in = 1'b1;
         out_rsp_in   = s1_rsp_cur;
      end
   end

   assign rsp_valid = out_valid_ff;
   assign rsp_data  = out_rsp_ff;

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         s1_decode_ff <= 1'b0;
         out_valid_ff <= 1'b0;
         cursor_ff    <= '0;
         inside_ff    <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         s1_decode_ff <= s1_decode_in;
         out_valid_ff <= out_valid_in;
         cursor_ff    <= cursor_in;
         inside_ff    <= inside_in;
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      s1_has_ff  <= s1_has_in;
      s1_rsp_ff  <= s1_rsp_in;
      out_rsp_ff <= out_rsp_in;
   end

   // Node store memory: builder writes, decoder reads with registered data.
   always_ff @(posedge clock) begin
      if (node_wr.we) begin
         node_mem[node_wr.addr] <= node_wr.data;
      end
      if (node_re) begin
         node_rd_ff <= node_mem[node_raddr];
      end
   end

endmodule

[rtl/core/hufd_tree_builder.sv]
// ----------------------------------------------------------------------------
// hufd_tree_builder: rebuilds the code tree from its preorder form
// Keeps the stack of open child slots in a synchronous memory with the top
// slot held in a register, so a request can follow every cycle. Produces the
// node store writes and the tree status.
// ----------------------------------------------------------------------------
module hufd_tree_builder (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    accept,
   input  hufd_pkg::req_type       req,
   output hufd_pkg::node_wr_type   node_wr,
   output hufd_pkg::build_stat_type stat
);

   hufd_pkg::status_type               status_ff, status_in;
   logic [hufd_pkg::DEPTH_W-1:0]       depth_ff, depth_in;
   logic [hufd_pkg::COUNT_W-1:0]       count_ff, count_in;
   hufd_pkg::slot_type                 top_ff, top_in;
   logic                               top_sel_ff, top_sel_in;
   hufd_pkg::slot_type                 stack_rd_ff;
   hufd_pkg::slot_type                 stack_mem [hufd_pkg::STACK_DEPTH];

   hufd_pkg::slot_type                 top_cur;
   logic                               push_we;
   logic [hufd_pkg::STACK_AW-1:0]      push_addr;
   hufd_pkg::slot_type                 push_data;
   logic                               pop_re;
   logic [hufd_pkg::STACK_AW-1:0]      pop_addr;
   logic                               tree_error;
   logic                               completed;

   // The top slot is either the register or the slot just read back.
   assign top_cur = top_sel_ff ? stack_rd_ff : top_ff;

   // Build step for one accepted request.
   always_comb begin
      status_in    = status_ff;
      depth_in     = depth_ff;
      count_in     = count_ff;
      top_in       = top_ff;
      top_sel_in   = top_sel_ff;
      push_we      = 1'b0;
      push_addr    = '0;
      push_data    = '0;
      pop_re       = 1'b0;
      pop_addr     = '0;
      tree_error   = 1'b0;
      completed    = 1'b0;
      node_wr      = '0;
      if (accept && req.operation == hufd_pkg::OP_BEGIN) begin
         depth_in   = '0;
         count_in   = '0;
         top_sel_in = 1'b0;
         status_in  = hufd_pkg::ST_BUILDING;
      end else if (accept && req.operation == hufd_pkg::OP_NODE) begin
         if (status_ff != hufd_pkg::ST_BUILDING) begin
            tree_error = 1'b1;
            status_in  = hufd_pkg::ST_FAILED;
         end else if (depth_ff == '0) begin
            // The root must be an internal node.
            if (!req.shape_bit) begin
               tree_error = 1'b1;
               status_in  = hufd_pkg::ST_FAILED;
            end else begin
               count_in       = hufd_pkg::COUNT_W'(1);
               push_we        = 1'b1;
               push_addr      = '0;
               push_data.node = '0;
               push_data.side = 1'b1;
               top_in.node    = '0;
               top_in.side    = 1'b0;
               top_sel_in     = 1'b0;
               depth_in       = hufd_pkg::DEPTH_W'(2);
            end
         end else if (req.shape_bit) begin
            if (count_ff >= hufd_pkg::COUNT_W'(hufd_pkg::MAX_INTERNAL_NODES)) begin
               tree_error = 1'b1;
               status_in  = hufd_pkg::ST_FAILED;
            end else begin
               // Fill the top slot with a new internal node and open its children.
               node_wr.we           = 1'b1;
               node_wr.addr         = {top_cur.node, top_cur.side};
               node_wr.data.leaf    = 1'b0;
               node_wr.data.payload =
                  hufd_pkg::PAYLOAD_W'(count_ff[hufd_pkg::NODE_W-1:0]);
               push_we        = 1'b1;
               push_addr      = hufd_pkg::STACK_AW'(depth_ff - 1'b1);
               push_data.node = count_ff[hufd_pkg::NODE_W-1:0];
               push_data.side = 1'b1;
               top_in.node    = count_ff[hufd_pkg::NODE_W-1:0];
               top_in.side    = 1'b0;
               top_sel_in     = 1'b0;
               depth_in       = depth_ff + 1'b1;
               count_in       = count_ff + 1'b1;
            end
         end else begin
            // A leaf fills the top slot; the slot below becomes the top.
            node_wr.we           = 1'b1;
            node_wr.addr         = {top_cur.node, top_cur.side};
            node_wr.data.leaf    = 1'b1;
            node_wr.data.payload =
               hufd_pkg::PAYLOAD_W'(req.leaf_symbol[hufd_pkg::SYMBOL_BITS-1:0]);
            depth_in = depth_ff - 1'b1;
            if (depth_ff == hufd_pkg::DEPTH_W'(1)) begin
               status_in = hufd_pkg::ST_COMPLETE;
               completed = 1'b1;
            end else begin
               pop_re     = 1'b1;
               pop_addr   = hufd_pkg::STACK_AW'(depth_ff - hufd_pkg::DEPTH_W'(2));
               top_sel_in = 1'b1;
            end
         end
      end
   end

   assign stat.tree_error = tree_error;
   assign stat.completed  = completed;
   assign stat.tree_ready = (status_ff == hufd_pkg::ST_COMPLETE);

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         status_ff  <= hufd_pkg::ST_EMPTY;
         depth_ff   <= '0;
         count_ff   <= '0;
         top_sel_ff <= 1'b0;
      end else begin
         status_ff  <= status_in;
         depth_ff   <= depth_in;
         count_ff   <= count_in;
         top_sel_ff <= top_sel_in;
      end
   end

   // Top slot register.
   always_ff @(posedge clock) begin
      top_ff <= top_in;
   end

   // Build stack memory with registered read.
   always_ff @(posedge clock) begin
      if (push_we) begin
         stack_mem[push_addr] <= push_data;
      end
      if (pop_re) begin
         stack_rd_ff <= stack_mem[pop_addr];
      end
   end

endmodule

[rtl/core/hufd_checker.sv]
// ----------------------------------------------------------------------------
// hufd_checker: port-level checks of the Huffman tree loader and decoder
// Watches the response channel for held results, clean unused fields and
// a quiet output after reset, and ties a request stall to a blocked response.
// ----------------------------------------------------------------------------
module hufd_checker (
   input logic              clock,
   input logic              reset,
   input logic              req_stall,
   input logic              rsp_valid,
   input logic              rsp_stall,
   input hufd_pkg::rsp_type rsp_data
);

   // A stalled response stays and holds its value.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_data))
      else $error("stalled response changed");

   // Only symbol results carry a symbol.
   a_symbol_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.kind != hufd_pkg::KIND_SYMBOL |-> rsp_data.symbol == 8'd0)
      else $error("nonzero symbol on a non-symbol result");

   // Only end results can report a dropped partial code.
   a_partial_end: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.partial_dropped |-> rsp_data.kind == hufd_pkg::KIND_END)
      else $error("partial code flag on a result that is not an end");

   // No response comes out of reset.
   a_reset_quiet: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("response valid right after reset");

   // Requests are stalled only while a response waits on a stalled output.
   a_stall_cause: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> rsp_valid && rsp_stall)
      else $error("request stalled without a blocked response");

endmodule

bind huffman_tree_load_and_decode hufd_checker u_hufd_checker (
   .clock     (clock),
   .reset     (reset),
   .req_stall (req_stall),
   .rsp_valid (rsp_valid),
   .rsp_stall (rsp_stall),
   .rsp_data  (rsp_data)
);
